/* rtl/core/anf_pkg.sv */
// Shared types and constants for the ANF coefficient engine.
`timescale 1ns / 1ps

package anf_pkg;

   // Default sizing of the truth table
   localparam int DEF_INPUT_BITS  = 8;
   localparam int DEF_OUTPUT_BITS = 2;

   // Fixed field widths
   localparam int CFG_W   = 4;
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 2;
   localparam int COEF_W  = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Transaction kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Work codes handed from front to back
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_QUERY = 2'd1,
      OP_FLAG  = 2'd2
   } op_type;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] entry_index;
      logic [VALUE_W-1:0] entry_value;
      logic [INDEX_W-1:0] query_term;
   } req_type;

   typedef struct packed {
      logic [COEF_W-1:0] coefficients;
      logic              term_out_of_range;
   } rsp_type;

   // One classified work item: addr is the entry index or the query term
   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] addr;
      logic [VALUE_W-1:0] value;
   } work_type;

endpackage

/* rtl/core/anf_front.sv */
// Front end: accepts transactions and classifies them into work items.
`timescale 1ns / 1ps

module anf_front import anf_pkg::*; (
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic [CFG_W-1:0] vars_used,
   output logic             push_valid,
   input  logic             push_ready,
   output work_type         push_entry
);

   logic index_ok;
   logic term_ok;
   logic keep;

   // Range checks against 2^vars_used
   assign index_ok = ((req_data.entry_index >> vars_used) == '0);
   assign term_ok  = ((req_data.query_term >> vars_used) == '0);

   // Classify; out-of-range writes are taken and dropped
   always_comb begin
      push_entry.value = req_data.entry_value;
      unique case (req_data.kind)
         KIND_WRITE: begin
            push_entry.op   = OP_WRITE;
            push_entry.addr = req_data.entry_index;
            keep            = index_ok;
         end
         KIND_QUERY: begin
            push_entry.op   = term_ok ? OP_QUERY : OP_FLAG;
            push_entry.addr = req_data.query_term;
            keep            = 1'b1;
         end
         default: begin
            push_entry.op   = OP_FLAG;
            push_entry.addr = req_data.query_term;
            keep            = 1'b0;
         end
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

/* rtl/core/anf_queue.sv */
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps

module anf_queue import anf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_entry,
   output logic     pop_valid,
   input  logic     pop,
   output work_type pop_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/anf_back.sv */
// Back end: truth table memory, subset scan with parity, response register.
`timescale 1ns / 1ps

module anf_back import anf_pkg::*; #(
   parameter int INPUT_BITS  = DEF_INPUT_BITS,
   parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] vars_used,
   input  logic             pop_valid,
   output logic             pop,
   input  work_type         pop_entry,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int DEPTH = 2 ** INPUT_BITS;
   localparam int AW    = (INPUT_BITS > INDEX_W) ? INPUT_BITS : INDEX_W;
   localparam int VW0   = (OUTPUT_BITS > VALUE_W) ? OUTPUT_BITS : VALUE_W;
   localparam int VW    = (VW0 > COEF_W) ? VW0 : COEF_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [INPUT_BITS-1:0]   idx_ff, idx_in;
   logic [INPUT_BITS-1:0]   term_ff, term_in;
   logic [OUTPUT_BITS-1:0]  acc_ff, acc_in;
   logic [OUTPUT_BITS-1:0]  acc_step;
   logic [OUTPUT_BITS-1:0]  rd_data_ff;
   logic                    hit_ff, hit_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    rsp_free;
   logic                    mem_we;
   logic [INPUT_BITS-1:0]   last_idx;
   logic [AW-1:0]           addr_wide;
   logic [INPUT_BITS-1:0]   entry_addr;
   logic [VW-1:0]           value_wide;
   logic [VW-1:0]           acc_wide;
   logic [OUTPUT_BITS-1:0]  tt_mem [DEPTH];

   // Width adaption of index, value and result
   assign addr_wide  = AW'(pop_entry.addr);
   assign entry_addr = addr_wide[INPUT_BITS-1:0];
   assign value_wide = VW'(pop_entry.value);
   assign acc_wide   = VW'(acc_ff);

   // Highest index of the active table: 2^vars_used - 1
   assign last_idx = ~({INPUT_BITS{1'b1}} << vars_used);

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign hit_in   = ((idx_ff & ~term_ff) == '0);
   assign acc_step = acc_ff ^ ((rd_valid_ff && hit_ff) ? rd_data_ff : '0);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      rd_valid_in  = 1'b0;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_entry.op)
                  OP_WRITE: begin
                     mem_we = 1'b1;
                     pop    = 1'b1;
                  end
                  OP_FLAG: begin
                     if (rsp_free) begin
                        pop                           = 1'b1;
                        rsp_valid_in                  = 1'b1;
                        rsp_data_in.coefficients      = '0;
                        rsp_data_in.term_out_of_range = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     pop      = 1'b1;
                     term_in  = entry_addr;
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            acc_in      = acc_step;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            acc_in   = acc_step;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.coefficients      = acc_wide[COEF_W-1:0];
               rsp_data_in.term_out_of_range = 1'b0;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      term_ff     <= term_in;
      acc_ff      <= acc_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Truth table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tt_mem[entry_addr] <= value_wide[OUTPUT_BITS-1:0];
      end
      rd_data_ff <= tt_mem[idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pop)
      else $error("queue popped while a scan is in progress");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= last_idx))
      else $error("scan index beyond table size");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && idx_ff == last_idx) |=> (state_ff == ST_FLUSH))
      else $error("scan did not end at last index");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.term_out_of_range) |-> (rsp_data_ff.coefficients == '0))
      else $error("flagged response carries coefficients");

endmodule

/* rtl/core/boolean_anf_transform_top.sv */
// Top level of the ANF coefficient engine: config register and the three units.
`timescale 1ns / 1ps

// Stores a truth table of up to 2^INPUT_BITS words and answers, per query
// transaction, the algebraic normal form coefficient of one monomial for each
// output bit. The back end takes a write when idle; an in-range query runs a
// scan that reads the single-port table memory one entry per cycle; an
// out-of-range query is answered from the idle state. The front end and a
// two-entry queue accept transactions while a scan runs or a response waits,
// until the queue fills. Writes to csr_write_data take effect at once and are
// to be made only while the block is idle; the block does not enforce this.
// 0 acts as 1 and values above INPUT_BITS act as INPUT_BITS. Table contents
// are undefined until written and survive a change of the variable count.
module boolean_anf_transform_top import anf_pkg::*; #(
   parameter int INPUT_BITS  = DEF_INPUT_BITS,
   parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data
);

   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [CFG_W-1:0] vars_used;
   logic             push_valid;
   logic             push_ready;
   work_type         push_entry;
   logic             pop_valid;
   logic             pop;
   work_type         pop_entry;

   // Variable count register
   assign cfg_in = csr_write_enable ? csr_write_data : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Clamp into 1..INPUT_BITS
   always_comb begin
      if (cfg_ff == '0) begin
         vars_used = CFG_W'(1);
      end else if (cfg_ff > CFG_W'(INPUT_BITS)) begin
         vars_used = CFG_W'(INPUT_BITS);
      end else begin
         vars_used = cfg_ff;
      end
   end

   anf_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .vars_used  (vars_used),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   anf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   anf_back #(
      .INPUT_BITS  (INPUT_BITS),
      .OUTPUT_BITS (OUTPUT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .vars_used (vars_used),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/anf_coefficient_checker.sv */
// Scoreboard for the ANF coefficient engine: mirrors the truth table and checks every response.
`timescale 1ns / 1ps

module anf_coefficient_checker import anf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data,
   output int               mismatch_count,
   output int               pending_count
);

   // Mirror of the block state
   logic [VALUE_W-1:0] truth_words [0:255];
   logic [CFG_W-1:0]   var_setting;
   rsp_type            coefficient_queue [$];

   // Register value clamped to the legal variable count
   function automatic int vars_for(input logic [CFG_W-1:0] setting);
      if (setting == 0) begin
         return 1;
      end
      if (setting > DEF_INPUT_BITS) begin
         return DEF_INPUT_BITS;
      end
      return int'(setting);
   endfunction

   // Moebius coefficient of one term: parity of every entry under the term mask
   function automatic rsp_type predict_response(input logic [INDEX_W-1:0] term);
      rsp_type            result;
      int                 size;
      logic [COEF_W-1:0]  parity;
      size   = 1 << vars_for(var_setting);
      parity = '0;
      result = '0;
      if (int'(term) >= size) begin
         result.term_out_of_range = 1'b1;
         return result;
      end
      for (int idx = 0; idx < size; idx++) begin
         if ((idx & ~int'(term)) == 0) begin
            parity = parity ^ truth_words[idx];
         end
      end
      result.coefficients = parity;
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR: %0t ns: %s", $time, what);
      mismatch_count = mismatch_count + 1;
   endtask

   // Apply one accepted transaction to the mirror
   task automatic apply_transaction(input req_type item);
      int size;
      size = 1 << vars_for(var_setting);
      if (item.kind == KIND_WRITE) begin
         if (int'(item.entry_index) < size) begin
            truth_words[item.entry_index] = item.entry_value;
         end
      end else begin
         coefficient_queue.push_back(predict_response(item.query_term));
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      var_setting    = CFG_RESET;
   end

   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         var_setting = CFG_RESET;
         coefficient_queue.delete();
         for (int idx = 0; idx < 256; idx++) begin
            truth_words[idx] = '0;
         end
      end else begin
         // Response side first: compare against the oldest outstanding query
         if (rsp_valid && rsp_ready) begin
            if (coefficient_queue.size() == 0) begin
               report_mismatch($sformatf("response coef=%b flag=%b with no query outstanding",
                                         rsp_data.coefficients, rsp_data.term_out_of_range));
            end else begin
               expected = coefficient_queue.pop_front();
               if (rsp_data.coefficients !== expected.coefficients) begin
                  report_mismatch($sformatf("coefficients %b, expected %b",
                                            rsp_data.coefficients, expected.coefficients));
               end
               if (rsp_data.term_out_of_range !== expected.term_out_of_range) begin
                  report_mismatch($sformatf("term_out_of_range %b, expected %b",
                                            rsp_data.term_out_of_range,
                                            expected.term_out_of_range));
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_transaction(req_data);
         end
         // Register write lands after any transaction of the same edge
         if (csr_write_enable) begin
            var_setting = csr_write_data;
         end
      end
      pending_count = coefficient_queue.size();
   end

endmodule

/* tb/tb_boolean_anf_transform_top.sv */
// Testbench top for the ANF coefficient engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_boolean_anf_transform_top;
   import anf_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;
   int               mismatch_count;
   int               pending_count;

   // Stimulus bookkeeping
   bit               calm;
   bit               written [0:255];
   int               active_vars;
   int               responses_seen;

   boolean_anf_transform_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   anf_coefficient_checker anf_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         responses_seen <= 0;
      end else if (rsp_valid && rsp_ready) begin
         responses_seen <= responses_seen + 1;
      end
   end

   // Receiver: random stall bursts, one long hold-off that backs up the block
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!calm && !long_hold_done && responses_seen >= 120) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic send_item(input req_type item);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_write(input int idx, input int value);
      req_type item;
      item.kind        = KIND_WRITE;
      item.entry_index = idx[INDEX_W-1:0];
      item.entry_value = value[VALUE_W-1:0];
      item.query_term  = INDEX_W'($urandom);
      if (idx < (1 << active_vars)) begin
         written[idx] = 1'b1;
      end
      send_item(item);
   endtask

   task automatic send_query(input int term);
      req_type item;
      item.kind        = KIND_QUERY;
      item.entry_index = INDEX_W'($urandom);
      item.entry_value = VALUE_W'($urandom);
      item.query_term  = term[INDEX_W-1:0];
      send_item(item);
   endtask

   // Wait for every response, then let a trailing write drain
   task automatic settle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_setting(input logic [CFG_W-1:0] value);
      settle();
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (value == 0) begin
         active_vars = 1;
      end else if (value > DEF_INPUT_BITS) begin
         active_vars = DEF_INPUT_BITS;
      end else begin
         active_vars = int'(value);
      end
   endtask

   // One configuration phase: fill missing entries, optional ascending sweep, random mix
   task automatic run_phase(input logic [CFG_W-1:0] setting, input int count,
                            input bit sweep, input bit mid_pause);
      int size;
      int pick;
      write_setting(setting);
      size = 1 << active_vars;
      for (int idx = 0; idx < size; idx++) begin
         if (!written[idx]) begin
            send_write(idx, $urandom_range(0, 3));
         end
      end
      if (sweep) begin
         for (int term = 0; term < size; term++) begin
            send_query(term);
         end
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_query($urandom_range(0, size - 1));
         end else if (pick < 65) begin
            send_query($urandom_range(0, 255));
         end else if (pick < 90) begin
            send_write($urandom_range(0, size - 1), $urandom_range(0, 3));
         end else begin
            send_write($urandom_range(0, 255), $urandom_range(0, 3));
         end
         if (mid_pause && n == count / 2) begin
            settle();
         end
      end
   endtask

   initial begin
      int waited;
      calm             = 1'b0;
      active_vars      = DEF_INPUT_BITS;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = CFG_RESET;
      for (int idx = 0; idx < 256; idx++) begin
         written[idx] = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one variable, ignored writes, flagged terms, extremes
      write_setting(4'd1);
      send_write(0, 3);
      send_write(1, 2);
      send_write(2, 1);
      send_write(255, 0);
      send_query(0);
      send_query(1);
      send_query(2);
      send_query(255);
      send_write(1, 0);
      send_query(1);
      // Zero register value behaves as one variable
      write_setting(4'd0);
      send_query(1);
      send_query(128);
      send_write(0, 0);
      send_query(0);
      // Register above the table size clamps to the full width
      write_setting(4'd15);
      send_write(255, 3);

      // Random phases over a spread of variable counts
      run_phase(4'd8, 95, 1'b0, 1'b0);
      run_phase(4'd2, 95, 1'b1, 1'b0);
      run_phase(4'd1, 95, 1'b1, 1'b0);
      run_phase(4'd3, 95, 1'b1, 1'b1);
      run_phase(4'd4, 95, 1'b1, 1'b0);
      run_phase(4'd5, 95, 1'b1, 1'b0);
      run_phase(4'd6, 95, 1'b0, 1'b0);
      run_phase(4'd7, 95, 1'b0, 1'b0);
      run_phase(4'd0, 95, 1'b1, 1'b0);
      run_phase(4'd12, 95, 1'b0, 1'b0);
      run_phase(4'd9, 95, 1'b0, 1'b0);
      // Final stretch at full speed on both sides
      calm = 1'b1;
      run_phase(4'd8, 95, 1'b0, 1'b0);

      // Drain, then allow one full scan for any stray response
      req_valid = 1'b0;
      for (waited = 0; pending_count != 0 && waited < 20000; waited++) begin
         @(negedge clock);
      end
      repeat (300) @(negedge clock);
      if (pending_count != 0) begin
         $display("ERROR: %0d queries never answered", pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* boolean_anf_transform_top.f */
rtl/core/anf_pkg.sv
rtl/core/anf_front.sv
rtl/core/anf_queue.sv
rtl/core/anf_back.sv
rtl/core/boolean_anf_transform_top.sv
tb/anf_coefficient_checker.sv
tb/tb_boolean_anf_transform_top.sv
